### hdl/ole_pkg.sv
package ole_pkg;

  localparam int unsigned DEF_CAPACITY = 32;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACT_W    = 4;
  localparam int unsigned INPOS_W  = 6;
  localparam int unsigned FPOS_W   = 5;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned OCNT_W   = 6;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR     = 4'd0,
    ACT_INS_FRONT = 4'd1,
    ACT_INS_BACK  = 4'd2,
    ACT_INS_AT    = 4'd3,
    ACT_DEL_FRONT = 4'd4,
    ACT_DEL_BACK  = 4'd5,
    ACT_DEL_AT    = 4'd6,
    ACT_RETRIEVE  = 4'd7,
    ACT_LOCATE    = 4'd8
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

endpackage

### hdl/ole_cell.sv
module ole_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 6
) (
  input  logic                       clk,
  input  ole_pkg::cell_op_t          op,
  input  logic [PW-1:0]              pos,
  input  logic [ole_pkg::DATA_W-1:0] key,
  input  logic [ole_pkg::DATA_W-1:0] left_entry,
  input  logic [ole_pkg::DATA_W-1:0] right_entry,
  output logic [ole_pkg::DATA_W-1:0] entry,
  output logic                       match
);

  localparam logic [PW-1:0] IDX_W = PW'(IDX);

  logic [ole_pkg::DATA_W-1:0] entry_r;
  logic [ole_pkg::DATA_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (op)
      ole_pkg::OP_INSERT: begin
        if (IDX_W > pos) begin
          entry_nxt = left_entry;
        end else if (IDX_W == pos) begin
          entry_nxt = key;
        end
      end
      ole_pkg::OP_DELETE: begin
        if (IDX_W >= pos) begin
          entry_nxt = right_entry;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r == key);

endmodule

### hdl/ordered_list_engine_unit.sv
// Bounded ordered list of signed 32-bit words held in a row of cells, one entry per
// cell. The command of each transaction is captured when accepted, then applied in
// a later cycle, where all cells shift, load or compare at once and the answer is
// loaded into the result register. The input is ready again right after that
// cycle, so the block does not take a new transaction until the last one is applied;
// the apply cycle waits only while the result register still holds an untaken answer.
// Entries are not cleared by reset; only positions below the count are ever read.
module ordered_list_engine_unit #(
  parameter int unsigned CAPACITY = ole_pkg::DEF_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] position, [37:6] value, [39:38] zero
  input  logic [ole_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [3:0] action
  input  logic [ole_pkg::ACT_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] found_value, [36:32] found_position, [42:37] entry_count, [47:43] zero
  output logic [ole_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [2:0] status
  output logic [ole_pkg::STAT_W-1:0]      out_tuser
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned W  = (CW > ole_pkg::INPOS_W) ? CW : ole_pkg::INPOS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic                               busy_r;
  ole_pkg::act_t                      cmd_act_r;
  logic [ole_pkg::INPOS_W-1:0]        cmd_pos_r;
  logic [ole_pkg::DATA_W-1:0]         cmd_val_r;
  logic [CW-1:0]                      count_r;
  logic [CW-1:0]                      count_nxt;

  logic                               out_valid_r;
  logic [ole_pkg::DATA_W-1:0]         out_fval_r;
  logic [ole_pkg::FPOS_W-1:0]         out_fpos_r;
  ole_pkg::status_t                   out_st_r;
  logic [ole_pkg::OCNT_W-1:0]         out_cnt_r;

  logic                               in_acc;
  logic                               exec;
  ole_pkg::cell_op_t                  op_sel;
  ole_pkg::cell_op_t                  cell_op;
  logic [W-1:0]                       op_pos;
  logic [W-1:0]                       pos_w;
  logic [W-1:0]                       cnt_w;
  logic [W-1:0]                       cnt_nxt_w;
  logic [W-1:0]                       fpos_w;
  logic [ole_pkg::DATA_W-1:0]         fval;
  ole_pkg::status_t                   st;
  logic                               hit;

  logic [ole_pkg::DATA_W-1:0]         entry  [CAPACITY];
  logic [CAPACITY-1:0]                match;

  assign in_tready = ~busy_r;
  assign in_acc    = in_tvalid & in_tready;
  assign exec      = busy_r & (~out_valid_r | out_tready);
  assign cell_op   = exec ? op_sel : ole_pkg::OP_HOLD;
  assign pos_w     = W'(cmd_pos_r);
  assign cnt_w     = W'(count_r);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ole_pkg::DATA_W-1:0] left_e;
    logic [ole_pkg::DATA_W-1:0] right_e;
    if (g == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = entry[g+1];
    end
    ole_cell #(
      .IDX (g),
      .PW  (W)
    ) u_cell (
      .clk         (clk),
      .op          (cell_op),
      .pos         (op_pos),
      .key         (cmd_val_r),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (entry[g]),
      .match       (match[g])
    );
  end

  always_comb begin
    logic [W-1:0] ipos;
    ipos      = '0;
    op_sel    = ole_pkg::OP_HOLD;
    op_pos    = '0;
    count_nxt = count_r;
    st        = ole_pkg::ST_OK;
    fval      = '0;
    fpos_w    = '0;
    hit       = 1'b0;
    unique case (cmd_act_r)
      ole_pkg::ACT_CLEAR: count_nxt = '0;
      ole_pkg::ACT_INS_FRONT, ole_pkg::ACT_INS_BACK, ole_pkg::ACT_INS_AT: begin
        if (cmd_act_r == ole_pkg::ACT_INS_FRONT) begin
          ipos = '0;
        end else if (cmd_act_r == ole_pkg::ACT_INS_BACK) begin
          ipos = cnt_w;
        end else begin
          ipos = pos_w;
        end
        if (ipos > cnt_w) begin
          st = ole_pkg::ST_BADPOS;
        end else if (count_r == CAP_C) begin
          st = ole_pkg::ST_FULL;
        end else begin
          op_sel    = ole_pkg::OP_INSERT;
          op_pos    = ipos;
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      ole_pkg::ACT_DEL_FRONT, ole_pkg::ACT_DEL_BACK, ole_pkg::ACT_DEL_AT: begin
        if (cmd_act_r == ole_pkg::ACT_DEL_FRONT) begin
          ipos = '0;
        end else if (cmd_act_r == ole_pkg::ACT_DEL_BACK) begin
          ipos = W'(cnt_w - 1'b1);
        end else begin
          ipos = pos_w;
        end
        if (count_r == '0) begin
          st = ole_pkg::ST_EMPTY;
        end else if (ipos >= cnt_w) begin
          st = ole_pkg::ST_BADPOS;
        end else begin
          op_sel    = ole_pkg::OP_DELETE;
          op_pos    = ipos;
          count_nxt = CW'(count_r - 1'b1);
        end
      end
      ole_pkg::ACT_RETRIEVE: begin
        if (count_r == '0) begin
          st = ole_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          st = ole_pkg::ST_BADPOS;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (pos_w == W'(i)) begin
              fval = fval | entry[i];
            end
          end
        end
      end
      ole_pkg::ACT_LOCATE: begin
        if (count_r == '0) begin
          st = ole_pkg::ST_EMPTY;
        end else begin
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match[i] && (W'(i) < cnt_w)) begin
              fpos_w = W'(i);
              hit    = 1'b1;
            end
          end
          if (!hit) begin
            st = ole_pkg::ST_NOTFOUND;
          end
        end
      end
      default: st = ole_pkg::ST_OK;
    endcase
  end

  assign cnt_nxt_w = W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (exec) begin
        busy_r <= 1'b0;
      end
      if (exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_act_r <= ole_pkg::act_t'(in_tuser);
      cmd_pos_r <= in_tdata[ole_pkg::INPOS_W-1:0];
      cmd_val_r <= in_tdata[ole_pkg::INPOS_W +: ole_pkg::DATA_W];
    end
    if (exec) begin
      out_fval_r <= fval;
      out_fpos_r <= fpos_w[ole_pkg::FPOS_W-1:0];
      out_st_r   <= st;
      out_cnt_r  <= cnt_nxt_w[ole_pkg::OCNT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_fpos_r, out_fval_r};
  assign out_tuser  = out_st_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("accepted transaction not pending");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_tvalid)
    else $error("executed transaction gave no result");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !exec |=> $stable(count_r))
    else $error("entry count changed outside execute");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_op == ole_pkg::OP_INSERT) |-> (count_r < CAP_C))
    else $error("insert into full list");

endmodule
